// ===== rtl/iso8583_field_validator_top_macros.svh =====
// assertion macros used by the checker file
`ifndef ISO8583_FIELD_VALIDATOR_TOP_MACROS_SVH
`define ISO8583_FIELD_VALIDATOR_TOP_MACROS_SVH

// checked only outside reset
`define IFV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IFV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ifv_pkg.sv =====
`default_nettype none

package ifv_pkg;

  localparam int COUNT_W           = 10;
  localparam int ACC_W             = 30;
  localparam int VALUE_W           = 31;
  localparam int DEF_MAX_FIELD_LEN = 999;
  localparam int MAX_DIGITS        = 9;
  localparam int N_MAX_LEN         = 9;
  localparam int XN_MAX_LEN        = 10;

  // character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [2:0] {
    TYPE_A   = 3'd0,
    TYPE_N   = 3'd1,
    TYPE_S   = 3'd2,
    TYPE_AN  = 3'd3,
    TYPE_AS  = 3'd4,
    TYPE_NS  = 3'd5,
    TYPE_ANS = 3'd6,
    TYPE_XN  = 3'd7
  } field_type_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CHAR = 2'd1,
    ST_SIGN = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef struct packed {
    field_type_t        active_type;
    logic               keep_text;
    logic [COUNT_W-1:0] byte_count;
    logic [ACC_W-1:0]   digit_accumulator;
    status_t            error_code;
    logic               negative_sign;
  } field_state_t;

  typedef struct packed {
    status_t                    status;
    logic                       is_number;
    logic signed [VALUE_W-1:0]  value;
    logic                       is_negative;
    logic [COUNT_W-1:0]         field_length;
  } field_result_t;

endpackage

`default_nettype wire

// ===== rtl/ifv_step.sv =====
`default_nettype none

module ifv_step #(
  parameter int MAX_FIELD_LEN = ifv_pkg::DEF_MAX_FIELD_LEN
) (
  input  ifv_pkg::field_state_t  cur,
  input  logic [7:0]             char_byte,
  input  logic                   first_byte,
  input  logic [2:0]             field_type,
  input  logic                   force_text,
  output ifv_pkg::field_state_t  nxt,
  output ifv_pkg::field_result_t res
);
  import ifv_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(MAX_FIELD_LEN);

  field_state_t     eff;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W:0] ndigits;
  logic             is_letter;
  logic             is_digit;
  logic             is_nonzero;
  logic             is_sign_d;
  logic             is_sign_c;
  status_t          check;
  logic [ACC_W-1:0] acc_times_ten;
  logic             numlike;
  logic [VALUE_W-1:0] mag;

  // state as seen by this byte: a first byte restarts the field
  always_comb begin
    eff = cur;
    if (first_byte) begin
      eff.active_type       = field_type_t'(field_type);
      eff.keep_text         = force_text;
      eff.byte_count        = '0;
      eff.digit_accumulator = '0;
      eff.error_code        = ST_OK;
      eff.negative_sign     = 1'b0;
    end
  end

  assign pos        = eff.byte_count;
  assign is_letter  = (char_byte >= CH_LOWER_A && char_byte <= CH_LOWER_Z) ||
                      (char_byte >= CH_UPPER_A && char_byte <= CH_UPPER_Z) ||
                      (char_byte == CH_SPACE);
  assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_nonzero = (char_byte != CH_NUL);
  assign is_sign_d  = (char_byte == CH_UPPER_D) || (char_byte == CH_LOWER_D);
  assign is_sign_c  = (char_byte == CH_UPPER_C) || (char_byte == CH_LOWER_C);

  // character class check for the active type
  always_comb begin
    unique case (eff.active_type)
      TYPE_A:  check = is_letter ? ST_OK : ST_CHAR;
      TYPE_N:  check = is_digit ? ST_OK : ST_CHAR;
      TYPE_AN: check = (is_letter || is_digit) ? ST_OK : ST_CHAR;
      TYPE_XN: begin
        if (pos == '0) begin
          check = (is_sign_c || is_sign_d) ? ST_OK : ST_SIGN;
        end else begin
          check = is_digit ? ST_OK : ST_CHAR;
        end
      end
      TYPE_S, TYPE_AS, TYPE_NS, TYPE_ANS: check = is_nonzero ? ST_OK : ST_CHAR;
      default: check = ST_CHAR;
    endcase
  end

  assign ndigits = (eff.active_type == TYPE_XN) ? {1'b0, pos} : ({1'b0, pos} + 1'b1);
  assign acc_times_ten = (eff.digit_accumulator << 3) + (eff.digit_accumulator << 1)
                       + {{(ACC_W-4){1'b0}}, char_byte[3:0]};

  always_comb begin
    nxt = eff;
    if (eff.error_code == ST_OK) begin
      if (pos >= MAX_LEN) begin
        nxt.error_code = ST_LONG;
      end else begin
        nxt.error_code = check;
      end
    end
    if (nxt.error_code == ST_OK) begin
      if (eff.active_type == TYPE_XN && pos == '0) begin
        nxt.negative_sign = is_sign_d;
      end else if (eff.active_type == TYPE_N || eff.active_type == TYPE_XN) begin
        if (ndigits <= (COUNT_W+1)'(MAX_DIGITS)) begin
          nxt.digit_accumulator = acc_times_ten;
        end
      end
    end
    if (eff.byte_count < MAX_LEN) begin
      nxt.byte_count = eff.byte_count + 1'b1;
    end
  end

  assign numlike = (nxt.error_code == ST_OK) &&
                   ((nxt.active_type == TYPE_N && !nxt.keep_text &&
                     nxt.byte_count <= COUNT_W'(N_MAX_LEN)) ||
                    (nxt.active_type == TYPE_XN &&
                     nxt.byte_count <= COUNT_W'(XN_MAX_LEN)));

  assign mag = {1'b0, nxt.digit_accumulator};

  always_comb begin
    res.status       = nxt.error_code;
    res.is_number    = numlike;
    res.is_negative  = nxt.negative_sign;
    res.field_length = nxt.byte_count;
    if (!numlike) begin
      res.value = '0;
    end else if (nxt.negative_sign) begin
      res.value = $signed(-mag);
    end else begin
      res.value = $signed(mag);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iso8583_field_validator_top.sv =====
// ISO 8583 field type checker. Bytes of one field arrive one per item
// transaction, with the field type and force-text flag taken on the byte
// marked first_byte. Each byte is checked against its type's class
// (letters and space, digits, both, or any nonzero byte; xn opens with
// C or D, then digits) and the first error found is kept. On the
// byte marked last_byte one result transaction carries status, field
// length (saturating at MAX_FIELD_LEN) and, for n fields of up to 9
// bytes not forced to text or xn fields of up to 10 bytes, the signed
// decimal value. A byte is taken every cycle unless a last byte is waiting
// in the input register. Each byte passes through the input register, and
// a last byte, when it leaves that register, loads the output register
// that drives result_valid and the result payload. The per-byte class
// check and the multiply-by-ten accumulate sit in one combinational step
// between the two registers. A last byte waits in the input register only
// while an earlier result is still held by result_ready low.
`default_nettype none

module iso8583_field_validator_top #(
  parameter int MAX_FIELD_LEN = ifv_pkg::DEF_MAX_FIELD_LEN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [7:0]          char_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  input  logic [2:0]          field_type,
  input  logic                force_text,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [1:0]          status,
  output logic                is_number,
  output logic signed [30:0]  value,
  output logic                is_negative,
  output logic [9:0]          field_length
);
  import ifv_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_first;
  logic       s1_last;
  logic [2:0] s1_type;
  logic       s1_force;

  // running field state
  field_state_t  st;
  field_state_t  st_next;
  field_result_t res;

  logic drain;

  // a byte leaves the input register unless it would produce a result
  // while the previous one is still waiting
  assign drain      = s1_valid && (!s1_last || !result_valid || result_ready);
  assign item_ready = !s1_valid || drain;

  ifv_step #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_step (
    .cur        (st),
    .char_byte  (s1_char),
    .first_byte (s1_first),
    .field_type (s1_type),
    .force_text (s1_force),
    .nxt        (st_next),
    .res        (res)
  );

  // control and field state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      st           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (drain) begin
        st <= st_next;
      end
      if (drain && s1_last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_char  <= char_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
      s1_type  <= field_type;
      s1_force <= force_text;
    end
  end

  // result payload, loaded when a last byte is processed
  always_ff @(posedge clk) begin
    if (drain && s1_last) begin
      status       <= res.status;
      is_number    <= res.is_number;
      value        <= res.value;
      is_negative  <= res.is_negative;
      field_length <= res.field_length;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ifv_checker.sv =====
`default_nettype none

`include "iso8583_field_validator_top_macros.svh"

module ifv_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [1:0]          status,
  input logic                is_number,
  input logic signed [30:0]  value,
  input logic                is_negative
);
  import ifv_pkg::*;

  `IFV_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result_valid,
                     "result valid after reset")

  `IFV_ASSERT(a_error_not_number, (result_valid && status != ST_OK) |-> !is_number,
              "error with number")

  `IFV_ASSERT(a_text_value_zero, (result_valid && !is_number) |-> (value == '0),
              "text value nonzero")

  `IFV_ASSERT(a_positive_sign,
              (result_valid && is_number && !is_negative) |-> !value[30],
              "sign mismatch")

  `IFV_ASSERT(a_result_hold,
              (result_valid && !result_ready) |=>
                (result_valid && $stable(value) && $stable(status)),
              "result dropped")

endmodule

bind iso8583_field_validator_top ifv_checker u_ifv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .status       (status),
  .is_number    (is_number),
  .value        (value),
  .is_negative  (is_negative)
);

`default_nettype wire
